[design/dat_pkg.sv]
// ----------------------------------------------------------------------------
// dat_pkg: shared types and constants of the daily alarm table
// Entry layout, result bundle, command and status codes, and limits.
// ----------------------------------------------------------------------------
`default_nettype none

package dat_pkg;

    localparam int DAT_MAX_ENTRIES = 8;
    localparam int DAT_MAX_RESULTS = 8;
    localparam int DAT_ID_LIMIT    = 250;

    localparam logic [4:0] DAT_HOUR_MAX   = 5'd23;
    localparam logic [5:0] DAT_MINUTE_MAX = 6'd59;

    localparam logic DAT_KIND_STATUS = 1'b0;
    localparam logic DAT_KIND_FIRED  = 1'b1;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_SET     = 2'd1,
        CMD_CANCEL  = 2'd2,
        CMD_DISMISS = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_TIME  = 3'd1,
        ST_NO_CLOCK  = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_READ,
        SEQ_EVAL,
        SEQ_DONE,
        SEQ_FLUSH
    } seq_state_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic        ringing;
        logic [26:0] fired_day;
    } entry_t;

    typedef struct packed {
        logic       kind;
        status_t    status;
        logic [7:0] id;
        logic [3:0] count;
        logic       last;
    } result_t;

endpackage

`default_nettype wire

[design/daily_alarm_table.sv]
// ----------------------------------------------------------------------------
// daily_alarm_table: ordered table of daily alarms
// Command beats in (tick, set, cancel, dismiss); status and fired-alarm
// beats out.
// ----------------------------------------------------------------------------
// Usage: one command beat is taken on the s_ channel when s_valid and s_ready
// are high; s_ready is high only while no command is in progress. Set, cancel
// and dismiss give exactly one status beat; a tick gives one beat per fired
// alarm (at most eight) or none, and a tick without a valid clock gives none.
// m_last marks the final beat of a command.
// Timing: the sequencer reads each stored alarm from the entry memory in
// SEQ_READ and evaluates the registered read data in SEQ_EVAL. A tick that
// walks the table ends in SEQ_FLUSH; set, cancel and dismiss pass through
// SEQ_DONE for hand-off and write-back before SEQ_FLUSH. Commands refused
// at once go straight to SEQ_FLUSH; a tick with nothing to walk stays in
// SEQ_IDLE. The last beat enters the output register from SEQ_FLUSH, once
// the register is free.
// Stalls: a low m_ready keeps one beat in the output register and one more
// pending; the walk waits on the next firing until space frees up.
// Reset: synchronous, active low; the table becomes empty. The entry memory
// is not cleared, since only entries below the fill count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module daily_alarm_table #(
    parameter int MAX_ENTRIES = dat_pkg::DAT_MAX_ENTRIES
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [1:0]  s_command,
    input  wire         s_clock_valid,
    input  wire  [4:0]  s_hour,
    input  wire  [5:0]  s_minute,
    input  wire  [26:0] s_day_key,
    input  wire  [7:0]  s_alarm_id,
    output logic        m_valid,
    input  wire         m_ready,
    output logic        m_kind,
    output logic [2:0]  m_status,
    output logic [7:0]  m_result_id,
    output logic [3:0]  m_entry_count,
    output logic        m_last
);
    import dat_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    entry_t        mem_wr_data;
    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    entry_t        mem_rd_data;
    logic          push;
    result_t       push_data;
    logic          out_free;

    dat_mem #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    dat_seq #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .AW          (AW),
        .CW          (CW)
    ) u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_clock_valid (s_clock_valid),
        .s_hour        (s_hour),
        .s_minute      (s_minute),
        .s_day_key     (s_day_key),
        .s_alarm_id    (s_alarm_id),
        .mem_wr_en     (mem_wr_en),
        .mem_wr_addr   (mem_wr_addr),
        .mem_wr_data   (mem_wr_data),
        .mem_rd_en     (mem_rd_en),
        .mem_rd_addr   (mem_rd_addr),
        .mem_rd_data   (mem_rd_data),
        .push          (push),
        .push_data     (push_data),
        .out_free      (out_free)
    );

    dat_out u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .push          (push),
        .push_data     (push_data),
        .out_free      (out_free),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_status      (m_status),
        .m_result_id   (m_result_id),
        .m_entry_count (m_entry_count),
        .m_last        (m_last)
    );

endmodule

`default_nettype wire

[design/dat_mem.sv]
// ----------------------------------------------------------------------------
// dat_mem: alarm entry memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module dat_mem #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  wire               aclk,
    input  wire               wr_en,
    input  wire  [AW-1:0]     wr_addr,
    input  dat_pkg::entry_t   wr_data,
    input  wire               rd_en,
    input  wire  [AW-1:0]     rd_addr,
    output dat_pkg::entry_t   rd_data
);
    import dat_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[design/dat_out.sv]
// ----------------------------------------------------------------------------
// dat_out: result output register
// Holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dat_out (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               push,
    input  dat_pkg::result_t  push_data,
    output logic              out_free,
    output logic              m_valid,
    input  wire               m_ready,
    output logic              m_kind,
    output logic [2:0]        m_status,
    output logic [7:0]        m_result_id,
    output logic [3:0]        m_entry_count,
    output logic              m_last
);
    import dat_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    assign out_free = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (push) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            data_reg <= push_data;
        end
    end

    assign m_valid       = valid_reg;
    assign m_kind        = data_reg.kind;
    assign m_status      = data_reg.status;
    assign m_result_id   = data_reg.id;
    assign m_entry_count = data_reg.count;
    assign m_last        = data_reg.last;

endmodule

`default_nettype wire

[design/dat_seq.sv]
// ----------------------------------------------------------------------------
// dat_seq: command sequencer of the daily alarm table
// Walks the entry memory at most once per command, reading, modifying and writing
// back entries, and builds the result beats.
// ----------------------------------------------------------------------------
`default_nettype none

module dat_seq #(
    parameter int MAX_ENTRIES = 8,
    parameter int AW          = 3,
    parameter int CW          = 4
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    output logic               s_ready,
    input  wire  [1:0]         s_command,
    input  wire                s_clock_valid,
    input  wire  [4:0]         s_hour,
    input  wire  [5:0]         s_minute,
    input  wire  [26:0]        s_day_key,
    input  wire  [7:0]         s_alarm_id,
    output logic               mem_wr_en,
    output logic [AW-1:0]      mem_wr_addr,
    output dat_pkg::entry_t    mem_wr_data,
    output logic               mem_rd_en,
    output logic [AW-1:0]      mem_rd_addr,
    input  dat_pkg::entry_t    mem_rd_data,
    output logic               push,
    output dat_pkg::result_t   push_data,
    input  wire                out_free
);
    import dat_pkg::*;

    // Ids up to MAX_ENTRIES + 1 are tracked; the smallest free id is always among them.
    localparam int NB = MAX_ENTRIES + 1;
    localparam int MW = $clog2(NB);

    seq_state_t  state_reg, state_next;
    cmd_t        cmd_reg, cmd_next;
    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  minute_reg, minute_next;
    logic [26:0] day_reg, day_next;
    logic [7:0]  aid_reg, aid_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] used_reg, used_next;
    logic        found_reg, found_next;
    logic [3:0]  fires_reg, fires_next;
    logic [NB-1:0] map_reg, map_next;
    logic        pend_valid_reg, pend_valid_next;
    result_t     pend_reg, pend_next;

    logic [CW-1:0] idx_plus;
    logic [CW-1:0] used_dec;
    logic [CW-1:0] used_inc;
    logic [7:0]    free_id;
    logic [7:0]    id_m1;
    logic          hit;
    logic          time_bad;
    entry_t        e;

    assign e        = mem_rd_data;
    assign idx_plus = idx_reg + 1'b1;
    assign used_dec = used_reg - 1'b1;
    assign used_inc = used_reg + 1'b1;
    assign id_m1    = e.id - 8'd1;
    assign time_bad = (s_hour > DAT_HOUR_MAX) || (s_minute > DAT_MINUTE_MAX);

    assign hit = !e.ringing && (e.fired_day != day_reg) && (e.hour == hour_reg)
              && (e.minute == minute_reg) && (fires_reg < 4'(DAT_MAX_RESULTS));

    // Lowest id that no entry holds.
    always_comb begin
        free_id = 8'd0;
        for (int k = NB - 1; k >= 0; k--) begin
            if (!map_reg[k]) begin
                free_id = 8'(k + 1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= SEQ_IDLE;
            used_reg       <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        hour_reg   <= hour_next;
        minute_reg <= minute_next;
        day_reg    <= day_next;
        aid_reg    <= aid_next;
        idx_reg    <= idx_next;
        found_reg  <= found_next;
        fires_reg  <= fires_next;
        map_reg    <= map_next;
        pend_reg   <= pend_next;
    end

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        hour_next       = hour_reg;
        minute_next     = minute_reg;
        day_next        = day_reg;
        aid_next        = aid_reg;
        idx_next        = idx_reg;
        used_next       = used_reg;
        found_next      = found_reg;
        fires_next      = fires_reg;
        map_next        = map_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;

        s_ready     = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = idx_reg[AW-1:0];
        mem_wr_data = e;
        mem_rd_en   = 1'b0;
        mem_rd_addr = idx_reg[AW-1:0];
        push        = 1'b0;
        push_data   = pend_reg;

        unique case (state_reg)
            SEQ_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_next        = cmd_t'(s_command);
                    hour_next       = s_hour;
                    minute_next     = s_minute;
                    day_next        = s_day_key;
                    aid_next        = s_alarm_id;
                    idx_next        = '0;
                    found_next      = 1'b0;
                    fires_next      = '0;
                    map_next        = '0;
                    pend_valid_next = 1'b0;
                    pend_next       = '{kind: DAT_KIND_STATUS, status: ST_OK, id: 8'd0,
                                        count: 4'(used_reg), last: 1'b0};
                    unique case (cmd_t'(s_command))
                        CMD_TICK: begin
                            if (s_clock_valid && used_reg != '0) begin
                                state_next = SEQ_READ;
                            end
                        end
                        CMD_SET: begin
                            if (time_bad) begin
                                pend_valid_next  = 1'b1;
                                pend_next.status = ST_BAD_TIME;
                                state_next       = SEQ_FLUSH;
                            end else if (!s_clock_valid) begin
                                pend_valid_next  = 1'b1;
                                pend_next.status = ST_NO_CLOCK;
                                state_next       = SEQ_FLUSH;
                            end else if (used_reg >= CW'(MAX_ENTRIES)) begin
                                pend_valid_next  = 1'b1;
                                pend_next.status = ST_FULL;
                                state_next       = SEQ_FLUSH;
                            end else if (used_reg == '0) begin
                                state_next = SEQ_DONE;
                            end else begin
                                state_next = SEQ_READ;
                            end
                        end
                        CMD_CANCEL, CMD_DISMISS: begin
                            if (used_reg == '0) begin
                                pend_valid_next  = 1'b1;
                                pend_next.status = ST_NOT_FOUND;
                                state_next       = SEQ_FLUSH;
                            end else begin
                                state_next = SEQ_READ;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            SEQ_READ: begin
                mem_rd_en  = 1'b1;
                state_next = SEQ_EVAL;
            end

            SEQ_EVAL: begin
                // A second firing while the output register is still full waits here.
                if (!(cmd_reg == CMD_TICK && hit && pend_valid_reg && !out_free)) begin
                    unique case (cmd_reg)
                        CMD_TICK: begin
                            if (hit) begin
                                mem_wr_en             = 1'b1;
                                mem_wr_data.ringing   = 1'b1;
                                mem_wr_data.fired_day = day_reg;
                                push                  = pend_valid_reg;
                                pend_valid_next       = 1'b1;
                                pend_next = '{kind: DAT_KIND_FIRED, status: ST_OK, id: e.id,
                                              count: 4'(used_reg), last: 1'b0};
                                fires_next = fires_reg + 4'd1;
                            end
                        end
                        CMD_SET: begin
                            if (e.id != 8'd0 && e.id <= 8'(NB)) begin
                                map_next[id_m1[MW-1:0]] = 1'b1;
                            end
                        end
                        CMD_CANCEL: begin
                            // Entries behind the cancelled one move down by one place.
                            if (found_reg) begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = idx_reg[AW-1:0] - 1'b1;
                            end else if (e.id == aid_reg) begin
                                found_next = 1'b1;
                            end
                        end
                        CMD_DISMISS: begin
                            if (!found_reg && e.id == aid_reg) begin
                                found_next          = 1'b1;
                                mem_wr_en           = 1'b1;
                                mem_wr_data.ringing = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                    idx_next = idx_plus;
                    if (idx_plus == used_reg) begin
                        state_next = (cmd_reg == CMD_TICK) ? SEQ_FLUSH : SEQ_DONE;
                    end else begin
                        state_next = SEQ_READ;
                    end
                end
            end

            SEQ_DONE: begin
                pend_valid_next = 1'b1;
                state_next      = SEQ_FLUSH;
                unique case (cmd_reg)
                    CMD_SET: begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = used_reg[AW-1:0];
                        mem_wr_data = '{id: free_id, hour: hour_reg, minute: minute_reg,
                                        ringing: 1'b0, fired_day: 27'd0};
                        used_next   = used_inc;
                        pend_next.id    = free_id;
                        pend_next.count = 4'(used_inc);
                    end
                    CMD_CANCEL: begin
                        if (found_reg) begin
                            used_next       = used_dec;
                            pend_next.count = 4'(used_dec);
                        end else begin
                            pend_next.status = ST_NOT_FOUND;
                        end
                    end
                    CMD_DISMISS: begin
                        if (!found_reg) begin
                            pend_next.status = ST_NOT_FOUND;
                        end
                    end
                    default: ;
                endcase
            end

            SEQ_FLUSH: begin
                push_data.last = 1'b1;
                if (!pend_valid_reg) begin
                    state_next = SEQ_IDLE;
                end else if (out_free) begin
                    push            = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = SEQ_IDLE;
                end
            end

            default: state_next = SEQ_IDLE;
        endcase
    end

endmodule

`default_nettype wire
